FILE: design/image_kernel_convolution_unit_defines.svh
// assertion macros shared by the convolution unit
`ifndef IMAGE_KERNEL_CONVOLUTION_UNIT_DEFINES_SVH
`define IMAGE_KERNEL_CONVOLUTION_UNIT_DEFINES_SVH

// same-cycle implication
`define IKC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IKC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ikc_pkg.sv
`timescale 1ns / 1ps

package ikc_pkg;

    localparam int MAX_WIDTH_DEF   = 256;
    localparam int MAX_HEIGHT_DEF  = 256;
    localparam int MAX_KERNEL_DEF  = 15;
    localparam int COEFF_FRAC_BITS = 14;

    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [8:0] WIDTH_RST  = 9'd256;
    localparam logic [8:0] HEIGHT_RST = 9'd256;
    localparam logic [3:0] KSIZE_RST  = 4'd3;

    typedef enum logic [1:0] {
        ACT_LOAD_PIXEL = 2'd0,
        ACT_LOAD_COEFF = 2'd1,
        ACT_COMPUTE    = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_KERNEL_SIZE  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         col;
        logic [7:0]         row;
        logic [7:0]         pixel_in;
        logic signed [15:0] coefficient;
    } in_req_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic [7:0] out_col;
        logic [7:0] out_row;
    } out_rsp_t;

    typedef struct packed {
        logic [8:0] w_eff;
        logic [8:0] h_eff;
        logic [3:0] k_eff;
    } geom_t;

    typedef struct packed {
        logic active;
        logic mac;
        logic last;
    } tap_ctl_t;

endpackage

FILE: design/ikc_ram.sv
`timescale 1ns / 1ps

module ikc_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ikc_window_seq.sv
`timescale 1ns / 1ps

module ikc_window_seq #(
    parameter int CW = 8,
    parameter int CH = 8,
    parameter int KW = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [7:0]         col,
    input  logic [7:0]         row,
    input  ikc_pkg::geom_t     geom,
    output logic [CH+CW-1:0]   frame_addr,
    output logic [2*KW-1:0]    kern_addr,
    output ikc_pkg::tap_ctl_t  tap,
    output logic               busy
);

    logic              run_reg;
    logic [3:0]        i_reg;
    logic [3:0]        j_reg;
    logic [7:0]        col_reg;
    logic [7:0]        row_reg;
    logic [CH+CW-1:0]  faddr_reg;
    logic [2*KW-1:0]   kaddr_reg;
    ikc_pkg::tap_ctl_t tap_reg;

    logic [2:0]        half;
    logic [3:0]        k_m1;
    logic [8:0]        w_m1;
    logic [8:0]        h_m1;
    logic signed [9:0] x_pos;
    logic signed [9:0] y_pos;
    logic [8:0]        a9;
    logic [8:0]        b9;
    logic [CW+8:0]     a_ext;
    logic [CH+8:0]     b_ext;
    logic [KW+3:0]     i_ext;
    logic [KW+3:0]     j_ext;
    logic              tap_last;

    always_comb begin
        half  = geom.k_eff[3:1];
        k_m1  = geom.k_eff - 4'd1;
        w_m1  = geom.w_eff - 9'd1;
        h_m1  = geom.h_eff - 9'd1;
        x_pos = $signed({2'b00, col_reg}) - $signed({7'd0, half}) + $signed({6'd0, i_reg});
        y_pos = $signed({2'b00, row_reg}) - $signed({7'd0, half}) + $signed({6'd0, j_reg});

        if (x_pos < 10'sd0) begin
            a9 = 9'd0;
        end else if (x_pos > $signed({1'b0, w_m1})) begin
            a9 = w_m1;
        end else begin
            a9 = x_pos[8:0];
        end

        if (y_pos < 10'sd0) begin
            b9 = 9'd0;
        end else if (y_pos > $signed({1'b0, h_m1})) begin
            b9 = h_m1;
        end else begin
            b9 = y_pos[8:0];
        end

        a_ext    = {{CW{1'b0}}, a9};
        b_ext    = {{CH{1'b0}}, b9};
        i_ext    = {{KW{1'b0}}, i_reg};
        j_ext    = {{KW{1'b0}}, j_reg};
        tap_last = (geom.k_eff == 4'd0) || ((i_reg == k_m1) && (j_reg == k_m1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            tap_reg <= '0;
        end else begin
            tap_reg <= '{active: run_reg, mac: (geom.k_eff != 4'd0), last: tap_last};
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && tap_last) begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        faddr_reg <= {b_ext[CH-1:0], a_ext[CW-1:0]};
        kaddr_reg <= {j_ext[KW-1:0], i_ext[KW-1:0]};
        if (start) begin
            i_reg   <= 4'd0;
            j_reg   <= 4'd0;
            col_reg <= col;
            row_reg <= row;
        end else if (run_reg && !tap_last) begin
            if (i_reg == k_m1) begin
                i_reg <= 4'd0;
                j_reg <= j_reg + 4'd1;
            end else begin
                i_reg <= i_reg + 4'd1;
            end
        end
    end

    assign frame_addr = faddr_reg;
    assign kern_addr  = kaddr_reg;
    assign tap        = tap_reg;
    assign busy       = run_reg;

endmodule

FILE: design/ikc_mac.sv
`timescale 1ns / 1ps

module ikc_mac #(
    parameter int MAX_KERNEL = 15
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  ikc_pkg::tap_ctl_t tap,
    input  logic [7:0]        pix,
    input  logic [15:0]       coef,
    output logic              res_valid,
    output logic [7:0]        res_pixel
);

    localparam int KCAP  = (MAX_KERNEL > 15) ? 15 : MAX_KERNEL;
    localparam int PW    = 25;
    localparam int ACC_W = PW + $clog2(KCAP * KCAP) + 1;
    localparam int FB    = ikc_pkg::COEFF_FRAC_BITS;
    localparam int QW    = ACC_W - FB;

    ikc_pkg::tap_ctl_t       tap_d1_reg;
    ikc_pkg::tap_ctl_t       tap_d2_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    fin_reg;
    logic                    res_valid_reg;
    logic [7:0]              res_pixel_reg;

    logic signed [PW-1:0]    prod;
    logic signed [ACC_W-1:0] rnd;
    logic [QW-1:0]           q;
    logic [7:0]              pix_sat;

    always_comb begin
        prod = $signed({1'b0, pix}) * $signed(coef);
        rnd  = acc_reg + $signed(ACC_W'(1) << (FB - 1));
        q    = rnd[ACC_W-1:FB];
        if (acc_reg <= $signed(ACC_W'(0))) begin
            pix_sat = 8'd0;
        end else if (q > QW'(255)) begin
            pix_sat = 8'd255;
        end else begin
            pix_sat = q[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_d1_reg    <= '0;
            tap_d2_reg    <= '0;
            fin_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            tap_d1_reg    <= tap;
            tap_d2_reg    <= tap_d1_reg;
            fin_reg       <= tap_d2_reg.active && tap_d2_reg.last;
            res_valid_reg <= fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= tap_d1_reg.mac ? prod : '0;
        if (start) begin
            acc_reg <= '0;
        end else if (tap_d2_reg.active && tap_d2_reg.mac) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (fin_reg) begin
            res_pixel_reg <= pix_sat;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_pixel = res_pixel_reg;

endmodule

FILE: design/image_kernel_convolution_unit.sv
// channel | signals                    | carries
// --------+----------------------------+---------------------------------------
// s_      | s_valid s_ready s_data     | load pixel, load coefficient, compute
// m_      | m_valid m_ready m_data     | filtered pixel with its column and row
// cfg_    | cfg_we cfg_index cfg_wdata | image width, image height, kernel size
//
// loads write the frame or kernel memory directly
// a compute request starts the window sequencer, which issues one tap per cycle to
//   the single read port of each memory
// synchronous active-low reset clears control only, memories hold no reset value
// one result waits in the output register while loads keep being taken; a
//   finished compute behind a stalled result holds until the register frees
`timescale 1ns / 1ps
`include "image_kernel_convolution_unit_defines.svh"

module image_kernel_convolution_unit #(
    parameter int MAX_WIDTH  = ikc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ikc_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_KERNEL = ikc_pkg::MAX_KERNEL_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ikc_pkg::in_req_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ikc_pkg::out_rsp_t               m_data,
    input  logic                            cfg_we,
    input  logic [ikc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ikc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CH   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int KW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int WCAP = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int HCAP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam int KCAP = (MAX_KERNEL > 15) ? 15 : MAX_KERNEL;
    localparam logic [8:0] WCAP9 = 9'(WCAP);
    localparam logic [8:0] HCAP9 = 9'(HCAP);
    localparam logic [3:0] KCAP4 = 4'(KCAP);

    logic [8:0]         width_reg;
    logic [8:0]         height_reg;
    logic [3:0]         ksize_reg;
    ikc_pkg::state_t    state_reg;
    ikc_pkg::state_t    state_next;
    logic               m_valid_reg;
    ikc_pkg::out_rsp_t  m_data_reg;
    logic [7:0]         out_col_reg;
    logic [7:0]         out_row_reg;

    ikc_pkg::geom_t     geom;
    logic               accept;
    logic               start;
    logic               deliver;
    logic               out_free;
    logic               frame_we;
    logic               kern_we;
    logic [CW+7:0]      col_ext;
    logic [CH+7:0]      row_ext;
    logic [KW+7:0]      kcol_ext;
    logic [KW+7:0]      krow_ext;
    logic [CH+CW-1:0]   frame_raddr;
    logic [2*KW-1:0]    kern_raddr;
    logic [7:0]         frame_rdata;
    logic [15:0]        kern_rdata;
    ikc_pkg::tap_ctl_t  tap;
    logic               seq_busy;
    logic               res_valid;
    logic [7:0]         res_pixel;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ikc_pkg::WIDTH_RST;
            height_reg <= ikc_pkg::HEIGHT_RST;
            ksize_reg  <= ikc_pkg::KSIZE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ikc_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                ikc_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                ikc_pkg::CFG_KERNEL_SIZE:  ksize_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == 9'd0) begin
            geom.w_eff = 9'd1;
        end else if (width_reg > WCAP9) begin
            geom.w_eff = WCAP9;
        end else begin
            geom.w_eff = width_reg;
        end
        if (height_reg == 9'd0) begin
            geom.h_eff = 9'd1;
        end else if (height_reg > HCAP9) begin
            geom.h_eff = HCAP9;
        end else begin
            geom.h_eff = height_reg;
        end
        geom.k_eff = (ksize_reg > KCAP4) ? KCAP4 : ksize_reg;
    end

    // request decode
    always_comb begin
        accept   = s_valid && s_ready;
        col_ext  = {{CW{1'b0}}, s_data.col};
        row_ext  = {{CH{1'b0}}, s_data.row};
        kcol_ext = {{KW{1'b0}}, s_data.col};
        krow_ext = {{KW{1'b0}}, s_data.row};
        frame_we = accept && (s_data.action == ikc_pkg::ACT_LOAD_PIXEL)
                   && (32'(s_data.col) < MAX_WIDTH) && (32'(s_data.row) < MAX_HEIGHT);
        kern_we  = accept && (s_data.action == ikc_pkg::ACT_LOAD_COEFF)
                   && (32'(s_data.col) < MAX_KERNEL) && (32'(s_data.row) < MAX_KERNEL);
        start    = accept && (s_data.action == ikc_pkg::ACT_COMPUTE);
    end

    ikc_ram #(
        .DATA_W (8),
        .ADDR_W (CH + CW)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (frame_we),
        .waddr ({row_ext[CH-1:0], col_ext[CW-1:0]}),
        .wdata (s_data.pixel_in),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    ikc_ram #(
        .DATA_W (16),
        .ADDR_W (2 * KW)
    ) u_kern_ram (
        .aclk  (aclk),
        .we    (kern_we),
        .waddr ({krow_ext[KW-1:0], kcol_ext[KW-1:0]}),
        .wdata (s_data.coefficient),
        .raddr (kern_raddr),
        .rdata (kern_rdata)
    );

    ikc_window_seq #(
        .CW (CW),
        .CH (CH),
        .KW (KW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .col        (s_data.col),
        .row        (s_data.row),
        .geom       (geom),
        .frame_addr (frame_raddr),
        .kern_addr  (kern_raddr),
        .tap        (tap),
        .busy       (seq_busy)
    );

    ikc_mac #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .tap       (tap),
        .pix       (frame_rdata),
        .coef      (kern_rdata),
        .res_valid (res_valid),
        .res_pixel (res_pixel)
    );

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ikc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        state_next = state_reg;
        deliver    = 1'b0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ikc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (start) begin
                    state_next = ikc_pkg::ST_BUSY;
                end
            end
            ikc_pkg::ST_BUSY: begin
                if (res_valid) begin
                    if (out_free) begin
                        deliver    = 1'b1;
                        state_next = ikc_pkg::ST_IDLE;
                    end else begin
                        state_next = ikc_pkg::ST_HOLD;
                    end
                end
            end
            ikc_pkg::ST_HOLD: begin
                if (out_free) begin
                    deliver    = 1'b1;
                    state_next = ikc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ikc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (deliver) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            out_col_reg <= s_data.col;
            out_row_reg <= s_data.row;
        end
        if (deliver) begin
            m_data_reg <= '{pixel_out: res_pixel, out_col: out_col_reg, out_row: out_row_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `IKC_ASSERT_IMPLIES(a_res_in_busy, aclk, aresetn, res_valid,
        state_reg == ikc_pkg::ST_BUSY, "result outside busy state")
    `IKC_ASSERT_IMPLIES(a_seq_idle, aclk, aresetn, state_reg == ikc_pkg::ST_IDLE,
        !seq_busy, "sequencer running while idle")
    `IKC_ASSERT_NEXT(a_start_runs, aclk, aresetn, start,
        seq_busy && (state_reg == ikc_pkg::ST_BUSY), "compute did not start")

endmodule
